// ----- src/nde_pkg.sv -----
// ----------------------------------------------------------------------------
// nde_pkg
// Shared widths, reset values and register indexes for the edge marker.
// ----------------------------------------------------------------------------
package nde_pkg;

	localparam int MAX_LINE = 1024;
	localparam int MAX_ROWS = 2048;
	localparam int MIN_WIDTH = 3;

	localparam int PIX_W   = 8;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 11;
	localparam int WIDTH_W = 11;
	localparam int CFG_A_W = 2;
	localparam int ADDR_W  = $clog2(MAX_LINE);
	localparam int CNT_W   = 4;

	// output beat layout
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USED_W = ROW_W + COL_W + PIX_W;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(720);
	localparam logic [PIX_W-1:0]   HIGH_RESET  = PIX_W'(255);
	localparam logic [PIX_W-1:0]   LOW_RESET   = PIX_W'(0);
	localparam logic [CNT_W-1:0]   EDGE_MIN    = CNT_W'(3);

	typedef enum logic [CFG_A_W-1:0] {
		CFG_LINE_WIDTH = 2'd0,
		CFG_HIGH_VALUE = 2'd1,
		CFG_LOW_VALUE  = 2'd2
	} cfg_idx_t;

endpackage

// ----- src/neighbor_difference_edge_mark.sv -----
// ----------------------------------------------------------------------------
// neighbor_difference_edge_mark
// 3x3 neighbor difference count over a raster luma stream, marks edge pixels.
// ----------------------------------------------------------------------------
// Usage: luma samples enter on the s_ channel in raster order, one per beat,
// with s_tuser[0] set on the first pixel of a frame. For every interior pixel
// one beat leaves on the m_ channel carrying its row, column, edge flag and
// the replacement luma (high_value or low_value). Border pixels give no beat.
// The result for pixel (r-1, c-1) is decided when sample (r, c) arrives, so
// results trail the input by one line and one pixel.
// Throughput: one sample per cycle unless a held result stalls the input. An
// input beat passes the line memory read, then the decision register, on its
// way to m_tvalid. The two previous lines sit in one dual-lane line memory,
// read when a sample is accepted and written back when the decision stage
// retires; a same-column read that meets the pending write is forwarded.
// Reset clears the counters, the window and the config registers (width 720,
// high 255, low 0); the line memory is not cleared and needs no sweep.
// When m_tready is low the result is held, the next sample is still taken
// while the decision stage is free, and after that s_tready drops.
// Config writes (cfg_we, cfg_addr, cfg_wdata) are meant for idle periods.
// ----------------------------------------------------------------------------
module neighbor_difference_edge_mark (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nde_pkg::CFG_A_W-1:0]   cfg_addr,
	input  logic [nde_pkg::WIDTH_W-1:0]   cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] luma
	input  logic [0:0]                    s_tuser,   // [0] frame_start
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [nde_pkg::OUT_DATA_W-1:0] m_tdata,  // [10:0] center_row,
	                                                 // [20:11] center_col,
	                                                 // [28:21] luma_out, rest 0
	output logic [0:0]                    m_tuser    // [0] edge_flag
);
	import nde_pkg::*;

	// configuration
	logic [WIDTH_W-1:0] width_q;
	logic [PIX_W-1:0]   high_q;
	logic [PIX_W-1:0]   low_q;
	logic [WIDTH_W-1:0] w_eff;

	// counters
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   c0;
	logic [ROW_W-1:0]   r0;
	logic [WIDTH_W-1:0] col_inc;
	logic               wrap;
	logic               in_fire;

	// line memory: [15:8] two lines above, [7:0] line above
	logic [2*PIX_W-1:0] line_mem [MAX_LINE];
	logic [2*PIX_W-1:0] rd_q;

	// decision stage
	logic               s1_valid_q;
	logic [COL_W-1:0]   col_s1;
	logic [ROW_W-1:0]   row_s1;
	logic [PIX_W-1:0]   luma_s1;
	logic               fwd_s1;
	logic [PIX_W-1:0]   fwd_t_s1;
	logic [PIX_W-1:0]   fwd_m_s1;
	logic [PIX_W-1:0]   t_pix;
	logic [PIX_W-1:0]   m_pix;
	logic               emit;
	logic               s1_fire;
	logic [CNT_W-1:0]   diff_cnt;
	logic               is_edge;

	logic [PIX_W-1:0]   win_q [6];

	// output register
	logic               m_valid_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [COL_W-1:0]   out_col_q;
	logic [PIX_W-1:0]   out_luma_q;
	logic               out_edge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			high_q  <= HIGH_RESET;
			low_q   <= LOW_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_LINE_WIDTH: width_q <= cfg_wdata;
				CFG_HIGH_VALUE: high_q  <= cfg_wdata[PIX_W-1:0];
				CFG_LOW_VALUE:  low_q   <= cfg_wdata[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < WIDTH_W'(MIN_WIDTH)) begin
			w_eff = WIDTH_W'(MIN_WIDTH);
		end else if (width_q > WIDTH_W'(MAX_LINE)) begin
			w_eff = WIDTH_W'(MAX_LINE);
		end else begin
			w_eff = width_q;
		end
	end

	assign in_fire = s_tvalid && s_tready;
	assign c0      = s_tuser[0] ? '0 : col_q;
	assign r0      = s_tuser[0] ? '0 : row_q;
	assign col_inc = WIDTH_W'(c0) + WIDTH_W'(1);
	assign wrap    = (col_inc >= w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= (r0 < ROW_W'(MAX_ROWS - 1)) ? r0 + ROW_W'(1) : r0;
			end else begin
				col_q <= col_inc[COL_W-1:0];
				row_q <= r0;
			end
		end
	end

	// line memory, read on accept, written when the decision stage retires
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_q <= line_mem[c0[ADDR_W-1:0]];
		end
		if (s1_fire) begin
			line_mem[col_s1[ADDR_W-1:0]] <= {m_pix, luma_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_s1   <= c0;
			row_s1   <= r0;
			luma_s1  <= s_tdata;
			// pending write to the same column bypasses the memory
			fwd_s1   <= s1_valid_q && (col_s1 == c0);
			fwd_t_s1 <= m_pix;
			fwd_m_s1 <= luma_s1;
		end
	end

	assign t_pix = fwd_s1 ? fwd_t_s1 : rd_q[2*PIX_W-1:PIX_W];
	assign m_pix = fwd_s1 ? fwd_m_s1 : rd_q[PIX_W-1:0];

	assign emit    = (row_s1 >= ROW_W'(2)) && (col_s1 >= COL_W'(2));
	assign s1_fire = s1_valid_q && (!emit || !m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_fire;

	always_comb begin
		logic [PIX_W-1:0] nb [8];
		nb[0] = win_q[0];
		nb[1] = win_q[1];
		nb[2] = t_pix;
		nb[3] = win_q[2];
		nb[4] = m_pix;
		nb[5] = win_q[4];
		nb[6] = win_q[5];
		nb[7] = luma_s1;
		diff_cnt = '0;
		for (int i = 0; i < 8; i++) begin
			diff_cnt = diff_cnt + CNT_W'(nb[i] != win_q[3]);
		end
	end

	assign is_edge = (diff_cnt >= EDGE_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_fire) begin
			win_q[0] <= win_q[1];
			win_q[1] <= t_pix;
			win_q[2] <= win_q[3];
			win_q[3] <= m_pix;
			win_q[4] <= win_q[5];
			win_q[5] <= luma_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_fire && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			out_row_q  <= row_s1 - ROW_W'(1);
			out_col_q  <= col_s1 - COL_W'(1);
			out_edge_q <= is_edge;
			out_luma_q <= is_edge ? high_q : low_q;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {(OUT_DATA_W - OUT_USED_W)'(0), out_luma_q, out_col_q, out_row_q};
	assign m_tuser[0] = out_edge_q;

endmodule

// ----- src/nde_checker.sv -----
// ----------------------------------------------------------------------------
// nde_checker
// Port-level checks on the edge marker result stream, bound to the top level.
// ----------------------------------------------------------------------------
module nde_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [nde_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [0:0]                     m_tuser
);
	import nde_pkg::*;

	// a stalled result beat holds its content
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// only interior pixels are reported
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[ROW_W-1:0] != '0)
			&& (m_tdata[ROW_W+COL_W-1:ROW_W] != '0)
			&& (m_tdata[ROW_W+COL_W-1:ROW_W] != COL_W'(MAX_LINE - 1))
			&& (m_tdata[ROW_W-1:0] != ROW_W'(MAX_ROWS - 1)))
		else $error("border pixel reported");

	// padding bits stay clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:OUT_USED_W] == '0)
		else $error("nonzero padding in result beat");

	// no result in the first cycle out of reset
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

endmodule

bind neighbor_difference_edge_mark nde_checker u_nde_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
